/* rtl/ilie_pkg.sv */
package ilie_pkg;

    localparam int DEPTH = 16;
    localparam int WIDTH = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        CMD_APPEND    = 4'd0,
        CMD_POP_BACK  = 4'd1,
        CMD_INSERT    = 4'd2,
        CMD_ERASE     = 4'd3,
        CMD_READ      = 4'd4,
        CMD_FRONT     = 4'd5,
        CMD_BACK      = 4'd6,
        CMD_CLEAR     = 4'd7,
        CMD_SWAP      = 4'd8
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_ERASE,
        OP_SWAP
    } cell_op_t;

    typedef enum logic {
        S_RUN,
        S_SWAP
    } state_t;

    typedef struct packed {
        cell_op_t               op;
        logic [IDX_W-1:0]       pos_a;
        logic [IDX_W-1:0]       pos_b;
        logic [CNT_W-1:0]       count;
        logic [WIDTH-1:0]       wdata;
        logic [WIDTH-1:0]       xdata;
        logic [WIDTH-1:0]       tdata;
    } cell_ctl_t;

endpackage

/* rtl/ilie_cell.sv */
module ilie_cell
    import ilie_pkg::*;
(
    input  logic             clk,
    input  cell_ctl_t        ctl,
    input  logic [IDX_W-1:0] idx,
    input  logic [WIDTH-1:0] lower_q,
    input  logic [WIDTH-1:0] upper_q,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;
    logic [CNT_W-1:0] idx_ext;
    logic [CNT_W-1:0] pos_a_ext;

    assign idx_ext   = CNT_W'(idx);
    assign pos_a_ext = CNT_W'(ctl.pos_a);

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                if (idx == ctl.pos_a)
                begin
                    data_next = ctl.wdata;
                end
                else if (idx_ext > pos_a_ext && idx_ext <= ctl.count)
                begin
                    data_next = lower_q;
                end
            end
            OP_ERASE:
            begin
                if (idx_ext >= pos_a_ext && (idx_ext + CNT_W'(1)) < ctl.count)
                begin
                    data_next = upper_q;
                end
            end
            OP_SWAP:
            begin
                if (idx == ctl.pos_a)
                begin
                    data_next = ctl.xdata;
                end
                else if (idx == ctl.pos_b)
                begin
                    data_next = ctl.tdata;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

/* rtl/indexed_list_insert_erase.sv */
// ordered list of up to DEPTH words held in a row of cells, one word per cell
// command channel: an item is taken at a rising edge with start high and busy low
// result channel: done is high for one cycle with read_value, element_count, status
// the receiver cannot hold results off, so results are never delayed
// results are registered: the result appears in the cycle after the item is taken, except for
// a valid swap, which first passes through the S_SWAP state, during which busy is high
// one item per cycle while busy is low; a valid swap keeps busy high until its result is given
// insert and erase move all later cells up or down at once
// every read goes through a single read select over the cells
// reset clears the count and the control state; stored words are not cleared
// and are only read once written
module indexed_list_insert_erase
    import ilie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  command,
    input  logic [4:0]  position,
    input  logic [3:0]  second_position,
    input  logic [31:0] write_value,
    output logic        done,
    output logic [31:0] read_value,
    output logic [4:0]  element_count,
    output logic [1:0]  status
);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic             done_next;
    status_t          status_reg;
    status_t          status_next;
    logic [31:0]      rdata_reg;
    logic [31:0]      rdata_next;
    logic [IDX_W-1:0] pa_reg;
    logic [IDX_W-1:0] pa_next;
    logic [IDX_W-1:0] pb_reg;
    logic [IDX_W-1:0] pb_next;
    logic [WIDTH-1:0] tmp_reg;
    logic [WIDTH-1:0] tmp_next;

    cell_ctl_t        ctl;
    logic [IDX_W-1:0] rd_sel;
    logic [WIDTH-1:0] rd_data;
    logic [WIDTH-1:0] cell_q [DEPTH];
    logic [CNT_W-1:0] pa_ext;
    logic [CNT_W-1:0] pb_ext;
    logic [CNT_W-1:0] last_idx;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [WIDTH-1:0] lower_d;
            logic [WIDTH-1:0] upper_d;
            if (gi == 0)
            begin : g_first
                assign lower_d = '0;
            end
            else
            begin : g_mid_lo
                assign lower_d = cell_q[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign upper_d = '0;
            end
            else
            begin : g_mid_hi
                assign upper_d = cell_q[gi+1];
            end
            ilie_cell u_cell (
                .clk     (clk),
                .ctl     (ctl),
                .idx     (IDX_W'(gi)),
                .lower_q (lower_d),
                .upper_q (upper_d),
                .q       (cell_q[gi])
            );
        end
    endgenerate

    assign rd_data  = cell_q[rd_sel];
    assign pa_ext   = CNT_W'(position);
    assign pb_ext   = CNT_W'(second_position);
    assign last_idx = count_reg - CNT_W'(1);

    // read select
    always_comb
    begin
        rd_sel = IDX_W'(position);
        if (state_reg == S_SWAP)
        begin
            rd_sel = pb_reg;
        end
        else if (command == CMD_FRONT)
        begin
            rd_sel = '0;
        end
        else if (command == CMD_BACK)
        begin
            rd_sel = IDX_W'(last_idx);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = ST_OK;
        rdata_next  = '0;
        pa_next     = pa_reg;
        pb_next     = pb_reg;
        tmp_next    = tmp_reg;
        ctl.op      = OP_HOLD;
        ctl.pos_a   = IDX_W'(position);
        ctl.pos_b   = IDX_W'(second_position);
        ctl.count   = count_reg;
        ctl.wdata   = WIDTH'(write_value);
        ctl.xdata   = rd_data;
        ctl.tdata   = tmp_reg;
        case (state_reg)
            S_RUN:
            begin
                if (start)
                begin
                    done_next = 1'b1;
                    case (command)
                        CMD_APPEND:
                        begin
                            if (count_reg >= CNT_W'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ctl.op     = OP_INSERT;
                                ctl.pos_a  = IDX_W'(count_reg);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next = last_idx;
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (pa_ext > count_reg)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (count_reg >= CNT_W'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ctl.op     = OP_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_ERASE:
                        begin
                            if (pa_ext >= count_reg)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                ctl.op     = OP_ERASE;
                                count_next = last_idx;
                            end
                        end
                        CMD_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (pa_ext >= count_reg)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                rdata_next = 32'(rd_data);
                            end
                        end
                        CMD_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rdata_next = 32'(rd_data);
                            end
                        end
                        CMD_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rdata_next = 32'(rd_data);
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_SWAP:
                        begin
                            if (pa_ext >= count_reg || pb_ext >= count_reg)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = S_SWAP;
                                pa_next    = IDX_W'(position);
                                pb_next    = IDX_W'(second_position);
                                tmp_next   = rd_data;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_SWAP:
            begin
                ctl.op     = OP_SWAP;
                ctl.pos_a  = pa_reg;
                ctl.pos_b  = pb_reg;
                done_next  = 1'b1;
                state_next = S_RUN;
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_RUN;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= rdata_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        tmp_reg   <= tmp_next;
    end

    assign busy          = (state_reg == S_SWAP);
    assign done          = done_reg;
    assign read_value    = rdata_reg;
    assign element_count = 5'(count_reg);
    assign status        = status_reg;

    a_swap_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("swap did not finish in one extra cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("count beyond capacity");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == ST_FULL) |-> (count_reg == CNT_W'(DEPTH)))
        else $error("full reported while list not full");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == ST_EMPTY) |-> (count_reg == '0 && rdata_reg == '0))
        else $error("empty reported with entries or data");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg != ST_OK) |-> $stable(count_reg))
        else $error("count changed on a rejected item");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import ilie_pkg::*;

    localparam int QUIET_LIMIT = 400;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS = 100;

    typedef struct {
        cmd_t        cmd;
        logic [4:0]  pos;
        logic [3:0]  pos2;
        logic [31:0] data;
        int          gap;
        bit          drain;
    } list_item_t;

    typedef struct {
        logic [31:0] value;
        logic [4:0]  fill;
        status_t     st;
    } list_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [3:0]  command = 4'd0;
    logic [4:0]  position = 5'd0;
    logic [3:0]  second_position = 4'd0;
    logic [31:0] write_value = 32'd0;
    logic        busy;
    logic        done;
    logic [31:0] read_value;
    logic [4:0]  element_count;
    logic [1:0]  status;

    list_item_t   pending_items[$];
    list_result_t expected_results[$];

    logic [WIDTH-1:0] list_words[DEPTH];
    int               list_fill = 0;

    int n_taken = 0;
    int n_offered = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int total_items = 0;
    int gen_fill = 0;
    int gen_max_gap = 0;

    bit         staged = 1'b0;
    list_item_t staged_item;
    int         hold_left = 0;

    indexed_list_insert_erase u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .position        (position),
        .second_position (second_position),
        .write_value     (write_value),
        .done            (done),
        .read_value      (read_value),
        .element_count   (element_count),
        .status          (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic list_result_t predict_result(cmd_t cmd, logic [4:0] pa, logic [3:0] pb,
                                                    logic [31:0] wv);
        list_result_t r;
        logic [WIDTH-1:0] t;
        int k;
        r.value = '0;
        r.st = ST_OK;
        case (cmd)
            CMD_APPEND:
                if (list_fill >= DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    list_words[list_fill] = wv;
                    list_fill++;
                end
            CMD_POP_BACK:
                if (list_fill > 0)
                    list_fill--;
            CMD_INSERT:
                if (pa > list_fill)
                    r.st = ST_RANGE;
                else if (list_fill >= DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    for (k = list_fill; k > pa; k--)
                        list_words[k] = list_words[k - 1];
                    list_words[pa] = wv;
                    list_fill++;
                end
            CMD_ERASE:
                if (pa >= list_fill)
                    r.st = ST_RANGE;
                else
                begin
                    for (k = pa; k + 1 < list_fill; k++)
                        list_words[k] = list_words[k + 1];
                    list_fill--;
                end
            CMD_READ:
                if (list_fill == 0)
                    r.st = ST_EMPTY;
                else if (pa >= list_fill)
                    r.st = ST_RANGE;
                else
                    r.value = list_words[pa];
            CMD_FRONT:
                if (list_fill == 0)
                    r.st = ST_EMPTY;
                else
                    r.value = list_words[0];
            CMD_BACK:
                if (list_fill == 0)
                    r.st = ST_EMPTY;
                else
                    r.value = list_words[list_fill - 1];
            CMD_CLEAR:
                list_fill = 0;
            CMD_SWAP:
                if (pa >= list_fill || pb >= list_fill)
                    r.st = ST_RANGE;
                else
                begin
                    t = list_words[pa];
                    list_words[pa] = list_words[pb];
                    list_words[pb] = t;
                end
            default:
            begin
            end
        endcase
        r.fill = list_fill[4:0];
        return r;
    endfunction

    // fill level the list will have after an item, used to aim positions
    task automatic add_item(cmd_t cmd, int pa, int pb, logic [31:0] wv, bit drain);
        list_item_t it;
        it.cmd = cmd;
        it.pos = pa[4:0];
        it.pos2 = pb[3:0];
        it.data = wv;
        it.gap = $urandom_range(0, gen_max_gap);
        it.drain = drain;
        pending_items.insert(pending_items.size(), it);
        case (cmd)
            CMD_APPEND:    if (gen_fill < DEPTH) gen_fill++;
            CMD_POP_BACK:  if (gen_fill > 0) gen_fill--;
            CMD_INSERT:    if (pa <= gen_fill && gen_fill < DEPTH) gen_fill++;
            CMD_ERASE:     if (pa < gen_fill) gen_fill--;
            CMD_CLEAR:     gen_fill = 0;
            default:
            begin
            end
        endcase
    endtask

    task automatic add_random_item(bit grow, bit drain);
        int roll;
        int pa;
        int pb;
        logic [31:0] wv;
        cmd_t c;
        roll = $urandom_range(0, 99);
        if (roll < (grow ? 30 : 15))
            c = CMD_APPEND;
        else if (roll < (grow ? 50 : 25))
            c = CMD_INSERT;
        else if (roll < (grow ? 58 : 45))
            c = CMD_ERASE;
        else if (roll < (grow ? 63 : 58))
            c = CMD_POP_BACK;
        else if (roll < 77)
            c = CMD_READ;
        else if (roll < 81)
            c = CMD_FRONT;
        else if (roll < 85)
            c = CMD_BACK;
        else if (roll < 98)
            c = CMD_SWAP;
        else
            c = CMD_CLEAR;
        if ($urandom_range(0, 4) == 0)
            pa = $urandom_range(0, DEPTH);
        else if (c == CMD_INSERT)
            pa = $urandom_range(0, gen_fill);
        else if (gen_fill > 0)
            pa = $urandom_range(0, gen_fill - 1);
        else
            pa = 0;
        if ($urandom_range(0, 4) == 0 || gen_fill == 0)
            pb = $urandom_range(0, DEPTH - 1);
        else
            pb = $urandom_range(0, gen_fill - 1);
        case ($urandom_range(0, 9))
            0:       wv = 32'd0;
            1:       wv = 32'hFFFF_FFFF;
            default: wv = $urandom;
        endcase
        add_item(c, pa, pb, wv, drain);
    endtask

    always @(negedge clk)
    begin : drive
        logic raise;
        raise = 1'b0;
        if (rst_n)
        begin
            if (start && n_taken != n_offered)
                raise = 1'b1;
            else
            begin
                if (!staged && pending_items.size() > 0)
                begin
                    staged_item = pending_items.pop_front();
                    staged = 1'b1;
                    hold_left = staged_item.gap;
                end
                if (staged)
                begin
                    if (staged_item.drain && expected_results.size() != 0)
                        raise = 1'b0;
                    else if (hold_left > 0)
                        hold_left--;
                    else
                    begin
                        command <= staged_item.cmd;
                        position <= staged_item.pos;
                        second_position <= staged_item.pos2;
                        write_value <= staged_item.data;
                        raise = 1'b1;
                        n_offered++;
                        staged = 1'b0;
                    end
                end
            end
        end
        start <= raise;
    end

    always @(posedge clk)
    begin : watch
        list_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with no item outstanding");
                else
                begin
                    want = expected_results.pop_front();
                    if (read_value !== want.value)
                        report_mismatch($sformatf("read_value %0h, want %0h",
                                                  read_value, want.value));
                    if (element_count !== want.fill)
                        report_mismatch($sformatf("element_count %0d, want %0d",
                                                  element_count, want.fill));
                    if (status !== want.st)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  status, want.st));
                end
            end
            if (start && !busy)
            begin
                expected_results.insert(expected_results.size(),
                                        predict_result(cmd_t'(command), position,
                                                       second_position, write_value));
                n_taken <= n_taken + 1;
            end
            if (done || (start && !busy))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int i;
        int ph;
        // directed: empty list
        gen_max_gap = 3;
        add_item(CMD_FRONT, 0, 0, 32'd0, 1'b0);
        add_item(CMD_BACK, 0, 0, 32'd0, 1'b0);
        add_item(CMD_READ, 0, 0, 32'd0, 1'b0);
        add_item(CMD_POP_BACK, 0, 0, 32'd0, 1'b0);
        add_item(CMD_ERASE, 0, 0, 32'd0, 1'b0);
        add_item(CMD_SWAP, 0, 0, 32'd0, 1'b0);
        add_item(CMD_INSERT, 1, 0, 32'h1234_5678, 1'b0);
        add_item(CMD_INSERT, 0, 0, 32'hFFFF_FFFF, 1'b0);
        add_item(CMD_APPEND, 0, 0, 32'd0, 1'b0);
        add_item(CMD_INSERT, 16, 0, 32'hDEAD_BEEF, 1'b0);
        add_item(CMD_READ, 16, 0, 32'd0, 1'b0);
        add_item(CMD_READ, 1, 0, 32'd0, 1'b0);
        add_item(CMD_SWAP, 0, 15, 32'd0, 1'b0);
        add_item(CMD_SWAP, 1, 1, 32'd0, 1'b0);
        add_item(CMD_SWAP, 0, 1, 32'd0, 1'b0);
        // fill up
        for (i = 0; i < 14; i++)
            add_item(CMD_APPEND, 0, 0, (i % 2) ? 32'hAAAA_AAAA : $urandom, 1'b0);
        add_item(CMD_APPEND, 0, 0, 32'h5555_5555, 1'b0);
        add_item(CMD_INSERT, 16, 0, 32'h0F0F_0F0F, 1'b0);
        add_item(CMD_INSERT, 0, 0, 32'hF0F0_F0F0, 1'b0);
        add_item(CMD_READ, 15, 0, 32'd0, 1'b0);
        add_item(CMD_BACK, 0, 0, 32'd0, 1'b0);
        add_item(CMD_SWAP, 15, 0, 32'd0, 1'b0);
        add_item(CMD_FRONT, 0, 0, 32'd0, 1'b0);
        add_item(CMD_ERASE, 15, 0, 32'd0, 1'b0);
        add_item(CMD_ERASE, 0, 0, 32'd0, 1'b0);
        add_item(CMD_INSERT, 14, 0, 32'h8000_0001, 1'b0);
        add_item(CMD_READ, 14, 0, 32'd0, 1'b0);
        add_item(CMD_CLEAR, 0, 0, 32'd0, 1'b0);
        add_item(CMD_BACK, 0, 0, 32'd0, 1'b0);
        // random phases, each opened by a pause until the list has answered everything
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            gen_max_gap = (ph % 3 == 0) ? 0 : 12;
            for (i = 0; i < PHASE_ITEMS; i++)
                add_random_item(ph % 2 == 0, i == 0);
        end
        total_items = pending_items.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (n_taken < total_items)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("items left without a result");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/ilie_pkg.sv
rtl/ilie_cell.sv
rtl/indexed_list_insert_erase.sv
sim/testbench.sv
